>>> design/sfb_pkg.sv
`timescale 1ns / 1ps
// Shared types, marker bytes and CRC-16 (poly 0x1021) nibble functions for the
// stuffed frame builder. No dependencies.
package sfb_pkg;

    localparam logic [7:0] BYTE_START  = 8'h01;
    localparam logic [7:0] BYTE_END    = 8'h04;
    localparam logic [7:0] BYTE_ESCAPE = 8'h10;

    typedef struct packed {
        logic        start;
        logic        escape;
        logic [7:0]  data;
        logic        last;
        logic [15:0] crc;
    } sfb_entry_t;

    typedef struct packed {
        logic       push;
        sfb_entry_t entry;
    } sfb_push_t;

    typedef struct packed {
        logic       valid;
        sfb_entry_t entry;
    } sfb_head_t;

    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_ESC   = 6'b000010,
        PH_DATA  = 6'b000100,
        PH_CRCH  = 6'b001000,
        PH_CRCL  = 6'b010000,
        PH_END   = 6'b100000
    } sfb_phase_t;

    function automatic logic [15:0] nibble_crc(input logic [3:0] idx);
        logic [15:0] r;
        case (idx)
            4'h0: r = 16'h0000;
            4'h1: r = 16'h1021;
            4'h2: r = 16'h2042;
            4'h3: r = 16'h3063;
            4'h4: r = 16'h4084;
            4'h5: r = 16'h50a5;
            4'h6: r = 16'h60c6;
            4'h7: r = 16'h70e7;
            4'h8: r = 16'h8108;
            4'h9: r = 16'h9129;
            4'ha: r = 16'ha14a;
            4'hb: r = 16'hb16b;
            4'hc: r = 16'hc18c;
            4'hd: r = 16'hd1ad;
            4'he: r = 16'he1ce;
            4'hf: r = 16'hf1ef;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
        logic [3:0] idx;
        idx = crc[15:12] ^ nib;
        return nibble_crc(idx) ^ {crc[11:0], 4'h0};
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] mid;
        mid = crc_nibble(crc, b[7:4]);
        return crc_nibble(mid, b[3:0]);
    endfunction

endpackage

>>> design/sfb_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for payload beats and line beats.
// No dependencies.
interface sfb_payload_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       final_byte;

    modport source (output valid, output payload_byte, output final_byte, input ready);
    modport sink   (input valid, input payload_byte, input final_byte, output ready);
endinterface

interface sfb_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       frame_done;
    logic       run_last;

    modport source (output valid, output line_byte, output frame_done, output run_last,
                    input ready);
    modport sink   (input valid, input line_byte, input frame_done, input run_last,
                    output ready);
endinterface

>>> design/sfb_front.sv
`timescale 1ns / 1ps
// Front end: accepts payload beats, classifies them and advances the CRC.
// Depends on sfb_pkg and sfb_ifs.
module sfb_front (
    input  logic                clk,
    input  logic                rst_n,
    sfb_payload_if.sink         payload,
    input  logic                queue_full,
    output sfb_pkg::sfb_push_t  push
);

    logic        inside_frame_reg;
    logic        inside_frame_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_upd;
    logic        accept;

    assign payload.ready = !queue_full;
    assign accept        = payload.valid && !queue_full;
    assign crc_upd       = sfb_pkg::crc_byte(crc_reg, payload.payload_byte);

    always_comb
    begin
        push.push         = accept;
        push.entry.start  = !inside_frame_reg;
        push.entry.escape = (payload.payload_byte == sfb_pkg::BYTE_START) ||
                            (payload.payload_byte == sfb_pkg::BYTE_END) ||
                            (payload.payload_byte == sfb_pkg::BYTE_ESCAPE);
        push.entry.data   = payload.payload_byte;
        push.entry.last   = payload.final_byte;
        push.entry.crc    = crc_upd;

        inside_frame_next = inside_frame_reg;
        crc_next          = crc_reg;
        if (accept)
        begin
            inside_frame_next = !payload.final_byte;
            crc_next          = payload.final_byte ? 16'h0000 : crc_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_frame_reg <= 1'b0;
            crc_reg          <= 16'h0000;
        end
        else
        begin
            inside_frame_reg <= inside_frame_next;
            crc_reg          <= crc_next;
        end
    end

endmodule

>>> design/sfb_queue.sv
`timescale 1ns / 1ps
// Short queue of classified entries between the front and back ends.
// Depends on sfb_pkg.
module sfb_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sfb_pkg::sfb_push_t  push,
    output logic                full,
    output sfb_pkg::sfb_head_t  head,
    input  logic                pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sfb_pkg::sfb_entry_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head.valid = (count_reg != '0);
    assign head.entry = mem[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/sfb_back.sv
`timescale 1ns / 1ps
// Back end: walks each queued entry through its line beats into an output register.
// Depends on sfb_pkg and sfb_ifs.
module sfb_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sfb_pkg::sfb_head_t  head,
    output logic                pop,
    sfb_line_if.source          line
);

    sfb_pkg::sfb_phase_t phase_reg;
    sfb_pkg::sfb_phase_t phase_next;
    sfb_pkg::sfb_phase_t cur;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_done_reg;
    logic       out_last_reg;
    logic [7:0] beat_byte;
    logic       beat_done;
    logic       beat_last;
    logic       emit;

    assign emit = head.valid && (!out_valid_reg || line.ready);
    assign pop  = emit && beat_last;

    always_comb
    begin
        cur = phase_reg;
        if (cur == sfb_pkg::PH_START && !head.entry.start)
        begin
            cur = sfb_pkg::PH_ESC;
        end
        if (cur == sfb_pkg::PH_ESC && !head.entry.escape)
        begin
            cur = sfb_pkg::PH_DATA;
        end

        beat_byte  = head.entry.data;
        beat_done  = 1'b0;
        beat_last  = 1'b0;
        phase_next = phase_reg;
        case (cur)
            sfb_pkg::PH_START:
            begin
                beat_byte  = sfb_pkg::BYTE_START;
                phase_next = sfb_pkg::PH_ESC;
            end
            sfb_pkg::PH_ESC:
            begin
                beat_byte  = sfb_pkg::BYTE_ESCAPE;
                phase_next = sfb_pkg::PH_DATA;
            end
            sfb_pkg::PH_DATA:
            begin
                beat_byte  = head.entry.data;
                beat_last  = !head.entry.last;
                phase_next = head.entry.last ? sfb_pkg::PH_CRCH : sfb_pkg::PH_START;
            end
            sfb_pkg::PH_CRCH:
            begin
                beat_byte  = head.entry.crc[15:8];
                phase_next = sfb_pkg::PH_CRCL;
            end
            sfb_pkg::PH_CRCL:
            begin
                beat_byte  = head.entry.crc[7:0];
                phase_next = sfb_pkg::PH_END;
            end
            sfb_pkg::PH_END:
            begin
                beat_byte  = sfb_pkg::BYTE_END;
                beat_done  = 1'b1;
                beat_last  = 1'b1;
                phase_next = sfb_pkg::PH_START;
            end
            default:
            begin
                phase_next = sfb_pkg::PH_START;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (line.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= beat_byte;
            out_done_reg <= beat_done;
            out_last_reg <= beat_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= sfb_pkg::PH_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                phase_reg <= phase_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign line.valid      = out_valid_reg;
    assign line.line_byte  = out_byte_reg;
    assign line.frame_done = out_done_reg;
    assign line.run_last   = out_last_reg;

endmodule

>>> design/stuffed_frame_builder_crc16_core.sv
`timescale 1ns / 1ps
// Top level of the byte-stuffed frame builder with CRC-16.
// Depends on sfb_pkg, sfb_ifs, sfb_front, sfb_queue and sfb_back.
//
//   Channel   Role   Beat content
//   payload   sink   payload_byte, final_byte
//   line      source line_byte, frame_done, run_last
//
// The line side sends one beat per cycle while line.ready is high; an input beat
// yields one to six line beats, so a stream of plain bytes sustains one per cycle
// and a stuffed byte or frame edge adds beats that pass the single output register.
// The front takes a beat whenever the queue (QUEUE_DEPTH entries) has room.
// Reset clears the CRC, the frame flag, the queue and the output valid flag.
module stuffed_frame_builder_crc16_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    sfb_payload_if.sink   payload,
    sfb_line_if.source    line
);

    sfb_pkg::sfb_push_t push;
    sfb_pkg::sfb_head_t head;
    logic               queue_full;
    logic               pop;

    sfb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .payload    (payload),
        .queue_full (queue_full),
        .push       (push)
    );

    sfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    sfb_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .line  (line)
    );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for stuffed_frame_builder_crc16_core: drives payload beats with random gaps,
// predicts the framed line beats and compares each one as it arrives.
// Depends on sfb_pkg, sfb_ifs and the RTL of the frame builder.
module testbench;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 30;

    typedef struct {
        logic [7:0] line_byte;
        logic       frame_done;
        logic       run_last;
    } line_beat_t;

    logic clk;
    logic rst_n;

    sfb_payload_if pay_if ();
    sfb_line_if    line_if ();

    stuffed_frame_builder_crc16_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (pay_if),
        .line    (line_if)
    );

    line_beat_t  line_beats_due[$];
    logic [15:0] frame_crc;
    bit          frame_open;
    bit          idle_enabled;
    int          mismatches;
    int          cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic feedback;
        for (int i = 7; i >= 0; i--)
        begin
            feedback = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0};
            if (feedback)
                crc = crc ^ 16'h1021;
        end
        return crc;
    endfunction

    function automatic bit is_marker(input logic [7:0] b);
        return (b == sfb_pkg::BYTE_START) || (b == sfb_pkg::BYTE_END) ||
               (b == sfb_pkg::BYTE_ESCAPE);
    endfunction

    function automatic int draw_wait();
        if (!idle_enabled)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 18);
        return $urandom_range(0, 2);
    endfunction

    function automatic line_beat_t make_beat(input logic [7:0] b, input logic done);
        line_beat_t beat;
        beat.line_byte = b;
        beat.frame_done = done;
        beat.run_last = 1'b0;
        return beat;
    endfunction

    task automatic predict_line_beats(input logic [7:0] b, input logic fin);
        line_beat_t beats[$];
        if (!frame_open)
        begin
            beats.push_back(make_beat(sfb_pkg::BYTE_START, 1'b0));
            frame_open = 1'b1;
        end
        if (is_marker(b))
            beats.push_back(make_beat(sfb_pkg::BYTE_ESCAPE, 1'b0));
        beats.push_back(make_beat(b, 1'b0));
        frame_crc = crc16_update(frame_crc, b);
        if (fin)
        begin
            beats.push_back(make_beat(frame_crc[15:8], 1'b0));
            beats.push_back(make_beat(frame_crc[7:0], 1'b0));
            beats.push_back(make_beat(sfb_pkg::BYTE_END, 1'b1));
            frame_crc = 16'h0000;
            frame_open = 1'b0;
        end
        beats[beats.size() - 1].run_last = 1'b1;
        foreach (beats[i])
            line_beats_due.push_back(beats[i]);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            pay_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predict_line_beats(b, fin);
        pay_if.valid <= 1'b1;
        pay_if.payload_byte <= b;
        pay_if.final_byte <= fin;
        do
            @(posedge clk);
        while (!pay_if.ready);
    endtask

    task automatic wait_line_drained();
        pay_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (line_beats_due.size() != 0);
    endtask

    initial
    begin
        int stall;
        line_beat_t want;
        line_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                line_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            line_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (line_if.valid !== 1'b1);
            if (line_beats_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected line beat 0x%02h", line_if.line_byte));
            end
            else
            begin
                want = line_beats_due.pop_front();
                if (line_if.line_byte !== want.line_byte)
                    report_mismatch($sformatf("line_byte 0x%02h, expected 0x%02h",
                                              line_if.line_byte, want.line_byte));
                if (line_if.frame_done !== want.frame_done)
                    report_mismatch($sformatf("frame_done %b, expected %b",
                                              line_if.frame_done, want.frame_done));
                if (line_if.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last %b, expected %b",
                                              line_if.run_last, want.run_last));
            end
        end
    end

    task automatic test_single_byte_frames();
        logic [7:0] picks[5];
        picks = '{8'h00, 8'hff, sfb_pkg::BYTE_START, sfb_pkg::BYTE_END,
                  sfb_pkg::BYTE_ESCAPE};
        foreach (picks[i])
            send_byte(picks[i], 1'b1);
    endtask

    task automatic test_markers_inside_frame();
        logic [7:0] picks[7];
        picks = '{sfb_pkg::BYTE_START, sfb_pkg::BYTE_END, sfb_pkg::BYTE_ESCAPE,
                  8'h00, 8'hff, 8'h55, 8'haa};
        foreach (picks[i])
            send_byte(picks[i], i == 6);
    endtask

    // Single-byte frames whose CRC high or low byte equals a marker byte.
    task automatic test_crc_marker_bytes();
        logic [7:0]  markers[3];
        logic [15:0] crc;
        bit          found_low;
        bit          found_high;
        markers = '{sfb_pkg::BYTE_START, sfb_pkg::BYTE_END, sfb_pkg::BYTE_ESCAPE};
        foreach (markers[m])
        begin
            found_low = 1'b0;
            found_high = 1'b0;
            for (int b = 0; b < 256; b++)
            begin
                crc = crc16_update(16'h0000, b[7:0]);
                if (!found_low && crc[7:0] == markers[m])
                begin
                    send_byte(b[7:0], 1'b1);
                    found_low = 1'b1;
                end
                else if (!found_high && crc[15:8] == markers[m])
                begin
                    send_byte(b[7:0], 1'b1);
                    found_high = 1'b1;
                end
            end
        end
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 2))
                    0: return sfb_pkg::BYTE_START;
                    1: return sfb_pkg::BYTE_END;
                    default: return sfb_pkg::BYTE_ESCAPE;
                endcase
            end
            1: return $urandom_range(0, 1) ? 8'hff : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_random_frames(input int budget, input bit with_idle);
        int sent;
        int len;
        idle_enabled = with_idle;
        sent = 0;
        while (sent < budget)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
            begin
                send_byte(pick_payload(), i == len - 1);
                sent++;
            end
            if ($urandom_range(0, 9) == 0)
                wait_line_drained();
        end
    endtask

    task automatic test_pause_until_drained();
        send_byte(8'h3c, 1'b0);
        send_byte(sfb_pkg::BYTE_ESCAPE, 1'b0);
        wait_line_drained();
        send_byte(8'hc3, 1'b1);
        wait_line_drained();
        send_byte(8'h7e, 1'b1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        pay_if.valid <= 1'b0;
        pay_if.payload_byte <= 8'h00;
        pay_if.final_byte <= 1'b0;
        frame_crc = 16'h0000;
        frame_open = 1'b0;
        idle_enabled = 1'b1;
        mismatches = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_byte_frames();
        test_markers_inside_frame();
        test_crc_marker_bytes();
        test_pause_until_drained();
        test_random_frames(100, 1'b1);
        test_random_frames(30, 1'b0);
        idle_enabled = 1'b1;
        test_random_frames(8, 1'b1);

        wait_line_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && line_beats_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
